// ===== hdl/object_file_section_parser_unit_macros.svh =====
// ============================================================================
// Object file section parser assertion macros
// Shared concurrent assertion forms used by the parser modules.
// ============================================================================
`ifndef OBJECT_FILE_SECTION_PARSER_UNIT_MACROS_SVH
`define OBJECT_FILE_SECTION_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/osp_pkg.sv =====
// ============================================================================
// Object file section parser package
// Section codes, grammar phases, result kinds and the result record.
// ============================================================================
package osp_pkg;

   // Section header words.
   localparam logic [15:0] SEC_CODE = 16'hCADE;
   localparam logic [15:0] SEC_DATA = 16'hDADA;
   localparam logic [15:0] SEC_SYM  = 16'hC3B7;
   localparam logic [15:0] SEC_NAME = 16'hF17E;
   localparam logic [15:0] SEC_LINE = 16'h715E;

   // Bytes in a line record after its header.
   localparam logic [15:0] LINE_REC_BYTES = 16'd6;

   // Result kinds.
   localparam logic [1:0] KIND_CODE  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Position in the object file grammar.
   typedef enum logic [3:0] {
      PH_HDR_H = 4'd0,
      PH_HDR_L = 4'd1,
      PH_ADR_H = 4'd2,
      PH_ADR_L = 4'd3,
      PH_CNT_H = 4'd4,
      PH_CNT_L = 4'd5,
      PH_PAY_H = 4'd6,
      PH_PAY_L = 4'd7,
      PH_SKIP  = 4'd8
   } phase_type;

   // One result as produced by the parser for the consumed byte.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] write_address;
      logic [15:0] write_word;
   } result_type;

endpackage

// ===== hdl/osp_in_stage.sv =====
// ============================================================================
// Object file section parser input stage
// Registers one incoming byte and releases it when the parser advances.
// ============================================================================
module osp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte [7:0]
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // A new beat is taken when the register is empty or drains this cycle.
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

// ===== hdl/osp_parse_core.sv =====
// ============================================================================
// Object file section parser core
// Grammar state and the per-byte step that yields at most one result.
// ============================================================================
`include "object_file_section_parser_unit_macros.svh"

module osp_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   output osp_pkg::result_type result
);
   import osp_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic [7:0]  hold_ff,   hold_in;
   logic [15:0] section_ff, section_in;
   logic [15:0] addr_ff,   addr_in;
   logic [15:0] count_ff,  count_in;
   logic        error_ff,  error_in;
   logic [15:0] word;
   logic        is_load;

   assign word    = {hold_ff, data_byte};
   assign is_load = (section_ff == SEC_CODE) || (section_ff == SEC_DATA);

   // One grammar step for the byte in the input register.
   always_comb begin
      phase_in             = phase_ff;
      hold_in              = hold_ff;
      section_in           = section_ff;
      addr_in              = addr_ff;
      count_in             = count_ff;
      error_in             = error_ff;
      result.valid         = 1'b0;
      result.kind          = KIND_CODE;
      result.write_address = 16'd0;
      result.write_word    = 16'd0;
      if (!error_ff) begin
         case (phase_ff)
            PH_HDR_H, PH_ADR_H, PH_CNT_H, PH_PAY_H: begin
               hold_in  = data_byte;
               phase_in = phase_type'(phase_ff + 4'd1);
            end
            PH_HDR_L: begin
               section_in = word;
               if (word == SEC_CODE || word == SEC_DATA || word == SEC_SYM) begin
                  phase_in = PH_ADR_H;
               end else if (word == SEC_NAME) begin
                  phase_in = PH_CNT_H;
               end else if (word == SEC_LINE) begin
                  count_in = LINE_REC_BYTES;
                  phase_in = PH_SKIP;
               end else begin
                  error_in     = 1'b1;
                  phase_in     = PH_HDR_H;
                  result.valid = 1'b1;
                  result.kind  = KIND_ERROR;
               end
            end
            PH_ADR_L: begin
               addr_in  = word;
               phase_in = PH_CNT_H;
            end
            PH_CNT_L: begin
               count_in = word;
               if (word == 16'd0) begin
                  phase_in = PH_HDR_H;
               end else if (is_load) begin
                  phase_in = PH_PAY_H;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_PAY_L: begin
               result.valid         = 1'b1;
               result.kind          = (section_ff == SEC_CODE) ? KIND_CODE : KIND_DATA;
               result.write_address = addr_ff;
               result.write_word    = word;
               addr_in              = addr_ff + 16'd1;
               count_in             = count_ff - 16'd1;
               phase_in             = (count_ff == 16'd1) ? PH_HDR_H : PH_PAY_H;
            end
            PH_SKIP: begin
               count_in = count_ff - 16'd1;
               if (count_ff == 16'd1) begin
                  phase_in = PH_HDR_H;
               end
            end
            default: begin
               phase_in = PH_HDR_H;
            end
         endcase
      end
   end

   // State advances only when a byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR_H;
         hold_ff    <= 8'd0;
         section_ff <= 16'd0;
         addr_ff    <= 16'd0;
         count_ff   <= 16'd0;
         error_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         section_ff <= section_in;
         addr_ff    <= addr_in;
         count_ff   <= count_in;
         error_ff   <= error_in;
      end
   end

   // Once an error is latched it stays until reset.
   `OSP_ASSERT_NEXT(a_error_sticky, clock, reset, error_ff, error_ff, "error flag cleared")
   // A latched error silences every later byte.
   `OSP_ASSERT_NOW(a_silent_after_error, clock, reset, error_ff, !result.valid, "result after error")
   // Word writes come only from the low byte of a payload word.
   `OSP_ASSERT_NOW(a_write_phase, clock, reset, result.valid && result.kind != KIND_ERROR,
      phase_ff == PH_PAY_L, "word write outside payload")
   // An error comes only from a header word.
   `OSP_ASSERT_NOW(a_error_phase, clock, reset, result.valid && result.kind == KIND_ERROR,
      phase_ff == PH_HDR_L && result.write_word == 16'd0, "error outside header")

endmodule

// ===== hdl/osp_out_stage.sv =====
// ============================================================================
// Object file section parser output stage
// Result register that holds a beat until the downstream side takes it.
// ============================================================================
module osp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  osp_pkg::result_type result,
   output logic                slot_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,  // write_address [15:0], write_word [31:16]
   output logic [1:0]          rsp_tuser   // kind [1:0]
);
   import osp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [1:0]  kind_ff;
   logic [15:0] addr_ff;
   logic [15:0] word_ff;

   // The register can take a result when empty or emptying this cycle.
   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= result.kind;
         addr_ff <= result.write_address;
         word_ff <= result.write_word;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {word_ff, addr_ff};
   assign rsp_tuser  = kind_ff;

endmodule

// ===== hdl/object_file_section_parser_unit.sv =====
// ============================================================================
// Object file section parser unit
// Streams an object file in byte by byte and emits code and data word writes.
// ============================================================================
// The unit consumes one object file byte per clock with no gaps of its own:
// each byte is held in an input register while the parser takes its grammar
// step, and any word write or header error lands in a result register that
// feeds the output port. Input and output stall together only while the
// result register holds a beat the consumer has not yet taken. Code and data
// payload words come out as writes with big-endian assembly and 16-bit address
// wrap; symbol, file-name and line sections are skipped. An unknown header
// yields one error beat, after which all input is swallowed until reset.
module object_file_section_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // write_address [15:0], write_word [31:16]
   output logic [1:0]  rsp_tuser    // kind [1:0]
);
   import osp_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       slot_free;
   logic       advance;
   result_type result;

   // A byte moves through the parser whenever the result slot can take it.
   assign advance = byte_valid && slot_free;

   osp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   osp_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .data_byte (byte_data),
      .result    (result)
   );

   osp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result.valid),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/object_file_section_checker.sv =====
// ============================================================================
// Object file section parser checker
// Watches both streams of the parser, predicts every write and error beat
// from the accepted bytes, and compares each result beat in arrival order.
// ============================================================================
module object_file_section_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // write_address [15:0], write_word [31:16]
   input  logic [1:0]  rsp_tuser,   // kind [1:0]
   output int unsigned fail_count,
   output int unsigned pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import osp_pkg::*;

   // One predicted result beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [15:0] word;
   } load_beat_type;

   // Predicted parser state.
   phase_type   grammar_pos;
   logic [7:0]  held_msb;
   logic [15:0] cur_section;
   logic [15:0] next_addr;
   logic [15:0] left_count;
   logic        halted;

   load_beat_type expected_writes[$];

   // Advance the predicted grammar by one accepted byte.
   task automatic advance_parser(input logic [7:0] data_in);
      logic [15:0]   w;
      load_beat_type beat;
      w = {held_msb, data_in};
      if (halted) return;
      case (grammar_pos)
         PH_HDR_L: begin
            cur_section = w;
            if (w == SEC_CODE || w == SEC_DATA || w == SEC_SYM) begin
               grammar_pos = PH_ADR_H;
            end else if (w == SEC_NAME) begin
               grammar_pos = PH_CNT_H;
            end else if (w == SEC_LINE) begin
               left_count  = LINE_REC_BYTES;
               grammar_pos = PH_SKIP;
            end else begin
               // Unknown header: one error beat, then the parser goes silent.
               halted      = 1'b1;
               grammar_pos = PH_HDR_H;
               beat        = '{KIND_ERROR, 16'h0000, 16'h0000};
               expected_writes.push_back(beat);
            end
         end
         PH_ADR_L: begin
            next_addr   = w;
            grammar_pos = PH_CNT_H;
         end
         PH_CNT_L: begin
            left_count = w;
            if (w == 16'h0000) begin
               grammar_pos = PH_HDR_H;
            end else if (cur_section == SEC_CODE || cur_section == SEC_DATA) begin
               grammar_pos = PH_PAY_H;
            end else begin
               grammar_pos = PH_SKIP;
            end
         end
         PH_PAY_L: begin
            beat.kind    = (cur_section == SEC_CODE) ? KIND_CODE : KIND_DATA;
            beat.address = next_addr;
            beat.word    = w;
            expected_writes.push_back(beat);
            next_addr   = next_addr + 16'd1;
            left_count  = left_count - 16'd1;
            grammar_pos = (left_count == 16'h0000) ? PH_HDR_H : PH_PAY_H;
         end
         PH_SKIP: begin
            left_count = left_count - 16'd1;
            if (left_count == 16'h0000) grammar_pos = PH_HDR_H;
         end
         PH_HDR_H, PH_ADR_H, PH_CNT_H, PH_PAY_H: begin
            held_msb    = data_in;
            grammar_pos = phase_type'(grammar_pos + 4'd1);
         end
         default: begin
            grammar_pos = PH_HDR_H;
         end
      endcase
   endtask

   // Compare result beats first, then fold in the byte taken on this edge;
   // a byte never produces its result on the edge that accepts it.
   always @(posedge clock) begin
      load_beat_type got;
      load_beat_type want;
      if (reset) begin
         grammar_pos = PH_HDR_H;
         held_msb    = 8'h00;
         cur_section = 16'h0000;
         next_addr   = 16'h0000;
         left_count  = 16'h0000;
         halted      = 1'b0;
         expected_writes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]};
            if (expected_writes.size() == 0) begin
               $error("result beat with nothing expected: kind %0d, address %h, word %h",
                      got.kind, got.address, got.word);
               fail_count = fail_count + 1;
            end else begin
               want = expected_writes.pop_front();
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  fail_count = fail_count + 1;
               end
               if (got.address !== want.address) begin
                  $error("write_address: expected %h, got %h", want.address, got.address);
                  fail_count = fail_count + 1;
               end
               if (got.word !== want.word) begin
                  $error("write_word: expected %h, got %h", want.word, got.word);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) advance_parser(req_tdata);
      end
      pending_count = expected_writes.size();
   end

endmodule

// ===== tb/tb_object_file_section_parser_unit.sv =====
// ============================================================================
// Object file section parser testbench
// Streams well-formed object files with random content through the parser,
// under bursty input and a stalling consumer, and ends with a bad header.
// ============================================================================
module tb_object_file_section_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import osp_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // data_byte [7:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // write_address [15:0], write_word [31:16]
   logic [1:0]  rsp_tuser;    // kind [1:0]

   int unsigned fail_count;
   int unsigned pending_count;

   int          bytes_sent = 0;
   int          burst_left = 0;
   logic        hold_done  = 1'b0;

   object_file_section_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   object_file_section_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one byte, opening a new burst after a random gap when the last
   // one is used up. Called and returning at a falling edge.
   task automatic send_byte(input logic [7:0] data_in);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid = 1'b1;
      req_tdata  = data_in;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left = burst_left - 1;
      bytes_sent = bytes_sent + 1;
   endtask

   // Words travel high byte first.
   task automatic send_word(input logic [15:0] w);
      send_byte(w[15:8]);
      send_byte(w[7:0]);
   endtask

   // Payload words lean toward the all-zero and all-one extremes.
   function automatic logic [15:0] random_payload();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Code or data section with the given payload length.
   task automatic send_load(input logic [15:0] section, input logic [15:0] addr,
                            input logic [15:0] count);
      send_word(section);
      send_word(addr);
      send_word(count);
      repeat (count) send_word(random_payload());
   endtask

   // Symbol or file-name section whose bytes are skipped.
   task automatic send_skipped(input logic [15:0] section, input logic [15:0] count);
      send_word(section);
      if (section == SEC_SYM) send_word(16'($urandom));
      send_word(count);
      repeat (count) send_byte(8'($urandom));
   endtask

   // Line record: header plus address, line and file index.
   task automatic send_line_record();
      send_word(SEC_LINE);
      repeat (3) send_word(16'($urandom));
   endtask

   // One well-formed section with random shape and content.
   task automatic send_random_section();
      int          pick;
      int          r;
      logic [15:0] addr;
      logic [15:0] count;
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 99);
      if (pick < 60) begin
         if (r < 10) count = 16'd0;
         else if (r < 95) count = 16'($urandom_range(1, 6));
         else count = 16'($urandom_range(7, 40));
         r = $urandom_range(0, 99);
         // Some sections start right below the top so their addresses can wrap.
         if (r < 15) addr = 16'hFFFF - 16'($urandom_range(0, 4));
         else if (r < 20) addr = 16'h0000;
         else addr = 16'($urandom);
         send_load((pick < 35) ? SEC_CODE : SEC_DATA, addr, count);
      end else if (pick < 85) begin
         if (r < 15) count = 16'd0;
         else if (r < 95) count = 16'($urandom_range(1, 10));
         else count = 16'($urandom_range(256, 280));
         send_skipped((pick < 72) ? SEC_SYM : SEC_NAME, count);
      end else begin
         send_line_record();
      end
   endtask

   // Stimulus: directed sections, random sections, then a bad header.
   initial begin
      logic [15:0] bad_header;
      logic        drained_once;
      drained_once = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Code writes at the top of memory wrapping to zero, with extreme words.
      send_word(SEC_CODE);
      send_word(16'hFFFF);
      send_word(16'd2);
      send_word(16'hFFFF);
      send_word(16'h0000);
      // A data write at address zero.
      send_load(SEC_DATA, 16'h0000, 16'd1);
      // A file-name section that ends at its zero count.
      send_skipped(SEC_NAME, 16'd0);
      send_line_record();

      while (bytes_sent < 1200) begin
         // Once mid-run, let the parser drain completely before going on.
         if (!drained_once && bytes_sent >= 700) begin
            drained_once = 1'b1;
            req_tvalid   = 1'b0;
            do @(negedge clock); while (pending_count != 0);
         end
         send_random_section();
      end

      // An unknown header ends parsing; what follows must be swallowed.
      do begin
         bad_header = 16'($urandom);
      end while (bad_header == SEC_CODE || bad_header == SEC_DATA ||
                 bad_header == SEC_SYM || bad_header == SEC_NAME ||
                 bad_header == SEC_LINE);
      send_word(bad_header);
      send_load(SEC_CODE, 16'h1000, 16'd2);
      repeat (8) send_byte(8'($urandom));
      req_tvalid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_object_file_section_parser_unit: PASS");
      end else begin
         $display("tb_object_file_section_parser_unit: FAIL");
      end
      $finish;
   end

   // Consumer: spans of always-ready, half-ready, mostly-stalled and
   // mostly-ready behavior, with one long hold-off that backs up the parser.
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(negedge clock);
            if (!hold_done && bytes_sent >= 400) begin
               hold_done  = 1'b1;
               rsp_tready = 1'b0;
               repeat (200) @(negedge clock);
            end
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = 1'($urandom_range(0, 1));
               2:       rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb_object_file_section_parser_unit: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/osp_pkg.sv
hdl/osp_in_stage.sv
hdl/osp_parse_core.sv
hdl/osp_out_stage.sv
hdl/object_file_section_parser_unit.sv
tb/object_file_section_checker.sv
tb/tb_object_file_section_parser_unit.sv
